// ===== design/mcr_pkg.sv =====
// shared widths, register indexes and beat types for midpoint_clamped_to_radius
// no dependencies; imported by every module of the block
`default_nettype none

package mcr_pkg;

   // field widths
   localparam int IN_W       = 24;
   localparam int STATION_W  = 23;
   localparam int RADIUS_W   = 20;
   localparam int DIST_OUT_W = 24;
   localparam int CSR_W      = 23;
   localparam int CSR_IDX_W  = 2;

   // default saturation width of the result coordinates
   localparam int COORD_BITS_DEF = 24;

   // internal widths
   localparam int DELTA_W = 24;                  // magnitude of midpoint minus station
   localparam int SQ_W    = 2 * DELTA_W;         // one square
   localparam int RAD_W   = 2 * (DELTA_W + 1);   // radicand, even width
   localparam int ROOT_W  = RAD_W / 2;           // one root bit per stage
   localparam int REM_W   = ROOT_W + 2;          // root remainder
   localparam int NUM_W   = DELTA_W + RADIUS_W;  // delta times radius
   localparam int QUO_W   = RADIUS_W;            // quotient never exceeds the radius
   localparam int DREM_W  = ROOT_W;              // divider remainder, below the divisor
   localparam int FIN_W   = 26;                  // clamped coordinate before saturation
   localparam int SAT_W   = 34;                  // room for any COORD_BITS up to 32

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STATION_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATION_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS    = 2'd2;

   localparam logic [RADIUS_W-1:0] RADIUS_RST = 20'd320;

   // sideband carried through the root pipeline
   typedef struct packed {
      logic signed [IN_W-1:0] mid_x;
      logic signed [IN_W-1:0] mid_y;
      logic                   neg_x;
      logic                   neg_y;
      logic [DELTA_W-1:0]     adx;
      logic [DELTA_W-1:0]     ady;
   } sqrt_sb_type;

   // sideband carried through the divider pipeline
   typedef struct packed {
      logic signed [IN_W-1:0] mid_x;
      logic signed [IN_W-1:0] mid_y;
      logic                   neg_x;
      logic                   neg_y;
      logic [ROOT_W-1:0]      root_dist;
      logic                   clamped;
   } div_sb_type;

endpackage

`default_nettype wire

// ===== design/mcr_sqrt.sv =====
// pipelined floor integer square root, one root bit per stage, with sideband
// depends on mcr_pkg
`default_nettype none

module mcr_sqrt import mcr_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire logic [RAD_W-1:0]  in_rad,
   input  wire sqrt_sb_type       in_sb,
   output logic                   out_valid,
   output logic [ROOT_W-1:0]      out_root,
   output sqrt_sb_type            out_sb
);

   logic              v_ff    [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   sqrt_sb_type       sb_ff   [ROOT_W];

   logic              v_in    [ROOT_W];
   logic [REM_W-1:0]  rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   logic [RAD_W-1:0]  rad_in  [ROOT_W];
   sqrt_sb_type       sb_in   [ROOT_W];

   for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
      logic              pv;
      logic [REM_W-1:0]  prem;
      logic [ROOT_W-1:0] proot;
      logic [RAD_W-1:0]  prad;
      sqrt_sb_type       psb;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic [REM_W:0]    diff;

      if (g == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = '0;
         assign proot = '0;
         assign prad  = in_rad;
         assign psb   = in_sb;
      end else begin : g_next
         assign pv    = v_ff[g-1];
         assign prem  = rem_ff[g-1];
         assign proot = root_ff[g-1];
         assign prad  = rad_ff[g-1];
         assign psb   = sb_ff[g-1];
      end

      // one restoring step: bring down two radicand bits, try root*4+1
      always_comb begin
         rem_sh = {prem[REM_W-3:0], prad[RAD_W-1:RAD_W-2]};
         trial  = {proot, 2'b01};
         diff   = {1'b0, rem_sh} - {1'b0, trial};
         if (!diff[REM_W]) begin
            rem_in[g]  = diff[REM_W-1:0];
            root_in[g] = {proot[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[g]  = rem_sh;
            root_in[g] = {proot[ROOT_W-2:0], 1'b0};
         end
         rad_in[g] = {prad[RAD_W-3:0], 2'b00};
         v_in[g]   = pv;
         sb_in[g]  = psb;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROOT_W; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         for (int i = 0; i < ROOT_W; i++) v_ff[i] <= v_in[i];
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < ROOT_W; i++) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            rad_ff[i]  <= rad_in[i];
            sb_ff[i]   <= sb_in[i];
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_sb    = sb_ff[ROOT_W-1];

endmodule

`default_nettype wire

// ===== design/mcr_div.sv =====
// pipelined two-lane restoring divider, one quotient bit per stage
// depends on mcr_pkg; divisor is the distance in the sideband
`default_nettype none

module mcr_div import mcr_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num_x,
   input  wire logic [NUM_W-1:0]  in_num_y,
   input  wire div_sb_type        in_sb,
   output logic                   out_valid,
   output logic [QUO_W-1:0]       out_quo_x,
   output logic [QUO_W-1:0]       out_quo_y,
   output div_sb_type             out_sb
);

   logic              v_ff    [QUO_W];
   logic [DREM_W-1:0] remx_ff [QUO_W];
   logic [DREM_W-1:0] remy_ff [QUO_W];
   logic [QUO_W-1:0]  lox_ff  [QUO_W];
   logic [QUO_W-1:0]  loy_ff  [QUO_W];
   div_sb_type        sb_ff   [QUO_W];

   logic              v_in    [QUO_W];
   logic [DREM_W-1:0] remx_in [QUO_W];
   logic [DREM_W-1:0] remy_in [QUO_W];
   logic [QUO_W-1:0]  lox_in  [QUO_W];
   logic [QUO_W-1:0]  loy_in  [QUO_W];
   div_sb_type        sb_in   [QUO_W];

   for (genvar g = 0; g < QUO_W; g++) begin : g_stage
      logic              pv;
      logic [DREM_W-1:0] premx, premy;
      logic [QUO_W-1:0]  plox, ploy;
      div_sb_type        psb;
      logic [DREM_W:0]   shx, shy;
      logic [DREM_W+1:0] dfx, dfy;

      if (g == 0) begin : g_first
         // quotient fits QUO_W bits, so the upper dividend part starts below the divisor
         assign pv    = in_valid;
         assign premx = {{(DREM_W-(NUM_W-QUO_W)){1'b0}}, in_num_x[NUM_W-1:QUO_W]};
         assign premy = {{(DREM_W-(NUM_W-QUO_W)){1'b0}}, in_num_y[NUM_W-1:QUO_W]};
         assign plox  = in_num_x[QUO_W-1:0];
         assign ploy  = in_num_y[QUO_W-1:0];
         assign psb   = in_sb;
      end else begin : g_next
         assign pv    = v_ff[g-1];
         assign premx = remx_ff[g-1];
         assign premy = remy_ff[g-1];
         assign plox  = lox_ff[g-1];
         assign ploy  = loy_ff[g-1];
         assign psb   = sb_ff[g-1];
      end

      // bring down one dividend bit per lane, subtract the divisor if it fits
      always_comb begin
         shx = {premx, plox[QUO_W-1]};
         shy = {premy, ploy[QUO_W-1]};
         dfx = {1'b0, shx} - {2'b00, psb.root_dist};
         dfy = {1'b0, shy} - {2'b00, psb.root_dist};
         if (!dfx[DREM_W+1]) begin
            remx_in[g] = dfx[DREM_W-1:0];
            lox_in[g]  = {plox[QUO_W-2:0], 1'b1};
         end else begin
            remx_in[g] = shx[DREM_W-1:0];
            lox_in[g]  = {plox[QUO_W-2:0], 1'b0};
         end
         if (!dfy[DREM_W+1]) begin
            remy_in[g] = dfy[DREM_W-1:0];
            loy_in[g]  = {ploy[QUO_W-2:0], 1'b1};
         end else begin
            remy_in[g] = shy[DREM_W-1:0];
            loy_in[g]  = {ploy[QUO_W-2:0], 1'b0};
         end
         v_in[g]  = pv;
         sb_in[g] = psb;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUO_W; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         for (int i = 0; i < QUO_W; i++) v_ff[i] <= v_in[i];
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < QUO_W; i++) begin
            remx_ff[i] <= remx_in[i];
            remy_ff[i] <= remy_in[i];
            lox_ff[i]  <= lox_in[i];
            loy_ff[i]  <= loy_in[i];
            sb_ff[i]   <= sb_in[i];
         end
      end
   end

   assign out_valid = v_ff[QUO_W-1];
   assign out_quo_x = lox_ff[QUO_W-1];
   assign out_quo_y = loy_ff[QUO_W-1];
   assign out_sb    = sb_ff[QUO_W-1];

endmodule

`default_nettype wire

// ===== design/midpoint_clamped_to_radius.sv =====
// midpoint_clamped_to_radius: midpoint of station and contact, pulled onto the radius
// circle when outside it. Channels: req_ (contact_x/y in), rsp_ (mid_x/y, raw_distance,
// was_clamped out), both valid/ready; csr_ write port (0 station_x, 1 station_y,
// 2 radius), taken whenever csr_wr_en is high, meant for use while idle.
// An accepted req beat reaches its rsp beat through four front stages
// (midpoint, delta, squares, sum), 25 stages of root, one scaling multiply stage,
// 20 division stages and the output register; one beat enters per cycle unless stalled.
// The whole pipeline moves as one: when the rsp beat sits unaccepted, every stage
// holds and req_ready drops, so nothing is lost or repeated; bubbles advance as soon
// as rsp_ready is high or the output register is empty.
// Reset clears every valid bit and sets station to 0 and the radius to 320.
// Results saturate to the signed COORD_BITS range and then fill the 24-bit ports.
// Depends on mcr_pkg, mcr_sqrt and mcr_div.
`default_nettype none

module midpoint_clamped_to_radius import mcr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic signed [IN_W-1:0]  req_contact_x,
   input  wire logic signed [IN_W-1:0]  req_contact_y,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [IN_W-1:0]       rsp_mid_x,
   output logic signed [IN_W-1:0]       rsp_mid_y,
   output logic [DIST_OUT_W-1:0]        rsp_raw_distance,
   output logic                         rsp_was_clamped,
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_W-1:0]        csr_wdata
);

   localparam logic signed [SAT_W-1:0] SAT_HI = (SAT_W'(1) <<< (COORD_BITS - 1)) - SAT_W'(1);
   localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

   logic adv;

   // configuration registers
   logic [STATION_W-1:0] station_x_ff, station_y_ff;
   logic [RADIUS_W-1:0]  radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         station_x_ff <= '0;
         station_y_ff <= '0;
         radius_ff    <= RADIUS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STATION_X: station_x_ff <= csr_wdata[STATION_W-1:0];
            CSR_STATION_Y: station_y_ff <= csr_wdata[STATION_W-1:0];
            CSR_RADIUS:    radius_ff    <= csr_wdata[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline advances unless the output beat is held
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // stage a: midpoint by floor half of the sum
   logic                   a_v_ff;
   logic signed [IN_W-1:0] a_mx_ff, a_my_ff;
   logic signed [IN_W:0]   sum_x, sum_y;

   always_comb begin
      sum_x = $signed({2'b00, station_x_ff}) + $signed({req_contact_x[IN_W-1], req_contact_x});
      sum_y = $signed({2'b00, station_y_ff}) + $signed({req_contact_y[IN_W-1], req_contact_y});
   end

   // stage b: delta from station, sign and magnitude
   logic                   b_v_ff;
   logic signed [IN_W-1:0] b_mx_ff, b_my_ff;
   logic                   b_nx_ff, b_ny_ff;
   logic [DELTA_W-1:0]     b_ax_ff, b_ay_ff;
   logic signed [IN_W:0]   dx, dy;
   logic [IN_W:0]          ndx, ndy;

   always_comb begin
      dx  = $signed({a_mx_ff[IN_W-1], a_mx_ff}) - $signed({2'b00, station_x_ff});
      dy  = $signed({a_my_ff[IN_W-1], a_my_ff}) - $signed({2'b00, station_y_ff});
      ndx = -dx;
      ndy = -dy;
   end

   // stage c: squares
   logic        c_v_ff;
   sqrt_sb_type c_sb_ff;
   logic [SQ_W-1:0] c_sqx_ff, c_sqy_ff;

   // stage d: sum of squares
   logic             d_v_ff;
   sqrt_sb_type      d_sb_ff;
   logic [RAD_W-1:0] d_rad_ff;

   // valid bits of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
      end
   end

   // front stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         a_mx_ff <= sum_x[IN_W:1];
         a_my_ff <= sum_y[IN_W:1];
         b_mx_ff <= a_mx_ff;
         b_my_ff <= a_my_ff;
         b_nx_ff <= dx[IN_W];
         b_ny_ff <= dy[IN_W];
         b_ax_ff <= dx[IN_W] ? ndx[DELTA_W-1:0] : dx[DELTA_W-1:0];
         b_ay_ff <= dy[IN_W] ? ndy[DELTA_W-1:0] : dy[DELTA_W-1:0];
         c_sb_ff.mid_x <= b_mx_ff;
         c_sb_ff.mid_y <= b_my_ff;
         c_sb_ff.neg_x <= b_nx_ff;
         c_sb_ff.neg_y <= b_ny_ff;
         c_sb_ff.adx   <= b_ax_ff;
         c_sb_ff.ady   <= b_ay_ff;
         c_sqx_ff      <= b_ax_ff * b_ax_ff;
         c_sqy_ff      <= b_ay_ff * b_ay_ff;
         d_sb_ff       <= c_sb_ff;
         d_rad_ff      <= {{(RAD_W-SQ_W){1'b0}}, c_sqx_ff} + {{(RAD_W-SQ_W){1'b0}}, c_sqy_ff};
      end
   end

   // root pipeline
   logic              r_v;
   logic [ROOT_W-1:0] r_root;
   sqrt_sb_type       r_sb;

   mcr_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d_v_ff),
      .in_rad    (d_rad_ff),
      .in_sb     (d_sb_ff),
      .out_valid (r_v),
      .out_root  (r_root),
      .out_sb    (r_sb)
   );

   // stage e: clamp decision and delta times radius
   logic             e_v_ff;
   div_sb_type       e_sb_ff;
   logic [NUM_W-1:0] e_nx_ff, e_ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (adv) begin
         e_v_ff <= r_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_sb_ff.mid_x     <= r_sb.mid_x;
         e_sb_ff.mid_y     <= r_sb.mid_y;
         e_sb_ff.neg_x     <= r_sb.neg_x;
         e_sb_ff.neg_y     <= r_sb.neg_y;
         e_sb_ff.root_dist <= r_root;
         e_sb_ff.clamped   <= (r_root != '0) &&
                              (r_root >= {{(ROOT_W-RADIUS_W){1'b0}}, radius_ff});
         e_nx_ff           <= r_sb.adx * radius_ff;
         e_ny_ff           <= r_sb.ady * radius_ff;
      end
   end

   // divider pipeline
   logic             q_v;
   logic [QUO_W-1:0] q_x, q_y;
   div_sb_type       q_sb;

   mcr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (e_v_ff),
      .in_num_x  (e_nx_ff),
      .in_num_y  (e_ny_ff),
      .in_sb     (e_sb_ff),
      .out_valid (q_v),
      .out_quo_x (q_x),
      .out_quo_y (q_y),
      .out_sb    (q_sb)
   );

   // final coordinate: station plus signed quotient, or the plain midpoint
   logic signed [FIN_W-1:0] off_x, off_y, fin_x, fin_y;
   logic signed [SAT_W-1:0] wide_x, wide_y, sat_x, sat_y;

   always_comb begin
      off_x = q_sb.neg_x ? -$signed({{(FIN_W-QUO_W){1'b0}}, q_x})
                         :  $signed({{(FIN_W-QUO_W){1'b0}}, q_x});
      off_y = q_sb.neg_y ? -$signed({{(FIN_W-QUO_W){1'b0}}, q_y})
                         :  $signed({{(FIN_W-QUO_W){1'b0}}, q_y});
      if (q_sb.clamped) begin
         fin_x = $signed({{(FIN_W-STATION_W){1'b0}}, station_x_ff}) + off_x;
         fin_y = $signed({{(FIN_W-STATION_W){1'b0}}, station_y_ff}) + off_y;
      end else begin
         fin_x = FIN_W'(q_sb.mid_x);
         fin_y = FIN_W'(q_sb.mid_y);
      end
      wide_x = SAT_W'(fin_x);
      wide_y = SAT_W'(fin_y);
      if (wide_x > SAT_HI)      sat_x = SAT_HI;
      else if (wide_x < SAT_LO) sat_x = SAT_LO;
      else                      sat_x = wide_x;
      if (wide_y > SAT_HI)      sat_y = SAT_HI;
      else if (wide_y < SAT_LO) sat_y = SAT_LO;
      else                      sat_y = wide_y;
   end

   // output register
   logic                   out_v_ff;
   logic signed [IN_W-1:0] out_x_ff, out_y_ff;
   logic [DIST_OUT_W-1:0]  out_dist_ff;
   logic                   out_clamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= q_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_x_ff     <= sat_x[IN_W-1:0];
         out_y_ff     <= sat_y[IN_W-1:0];
         out_dist_ff  <= q_sb.root_dist[ROOT_W-1] ? '1 : q_sb.root_dist[DIST_OUT_W-1:0];
         out_clamp_ff <= q_sb.clamped;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_mid_x        = out_x_ff;
   assign rsp_mid_y        = out_y_ff;
   assign rsp_raw_distance = out_dist_ff;
   assign rsp_was_clamped  = out_clamp_ff;

   // checks
   a_clamp_needs_radius: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_clamped |->
         rsp_raw_distance >= {{(DIST_OUT_W-RADIUS_W){1'b0}}, radius_ff})
      else $error("clamped beat with distance below radius");

   a_clamp_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_clamped |-> rsp_raw_distance != '0)
      else $error("clamped beat with zero distance");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(q_v) && $stable(e_v_ff) && $stable(d_v_ff))
      else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire
